@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// next-cycle implication under an active-low reset
`define ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/cci_pkg.sv @@
// constants for the circle collision impulse block
`default_nettype none

package cci_pkg;

    localparam int POS_W      = 20;
    localparam int VEL_W      = 21;
    localparam int RSUM_W     = 16;
    localparam int IM_W       = 16;
    localparam int RST_W      = 9;
    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 168;

    // squared distance fed to the root unit, and the root it gives
    localparam int SQ_W       = 32;
    localparam int DIST_W     = SQ_W / 2;

    localparam int NORM_FRAC  = 14;
    localparam int MASS_FRAC  = 12;

    // normal divider: |d| << 14 over dist
    localparam int ND_N       = DIST_W + NORM_FRAC;
    // impulse divider: numerator over inverse mass sum
    localparam int JD_N       = 38;
    localparam int IMS_W      = IM_W + 1;

    localparam logic [RST_W-1:0] RST_RESET = 9'd230;
    localparam logic [RST_W:0]   ONE_Q8    = 10'd256;

endpackage

`default_nettype wire

@@ rtl/cci_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`default_nettype none

module cci_sqrt #(
    parameter int X_W    = cci_pkg::SQ_W,
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [X_W-1:0]       in_x,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [X_W/2-1:0]     out_root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int RT_W  = X_W / 2;
    localparam int REM_W = RT_W + 2;

    logic              v_reg    [RT_W];
    logic [REM_W-1:0]  rem_reg  [RT_W];
    logic [RT_W-1:0]   root_reg [RT_W];
    logic [X_W-1:0]    x_reg    [RT_W];
    logic [SIDE_W-1:0] side_reg [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_stage
        logic              v_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [RT_W-1:0]   root_prev;
        logic [X_W-1:0]    x_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  diff;
        logic [REM_W-1:0]  trial;
        logic              fit;
        logic [REM_W-1:0]  rem_next;
        logic [RT_W-1:0]   root_next;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign x_prev    = in_x;
            assign side_prev = in_side;
        end else begin : g_rest
            assign v_prev    = v_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign x_prev    = x_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb begin
            rem_sh    = {rem_prev, x_prev[X_W-1 -: 2]};
            trial     = {root_prev, 2'b01};
            diff      = rem_sh - {2'b00, trial};
            fit       = (rem_sh >= {2'b00, trial});
            rem_next  = fit ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_next = {root_prev[RT_W-2:0], fit};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                x_reg[k]    <= {x_prev[X_W-3:0], 2'b00};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[RT_W-1];
    assign out_root  = root_reg[RT_W-1];
    assign out_side  = side_reg[RT_W-1];

endmodule

`default_nettype wire

@@ rtl/cci_div.sv @@
// pipelined restoring divider, two dividends over one divisor, one bit per stage
`default_nettype none

module cci_div #(
    parameter int N      = cci_pkg::JD_N,
    parameter int D      = cci_pkg::IMS_W,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [N-1:0]      in_dvd_a,
    input  logic [N-1:0]      in_dvd_b,
    input  logic [D-1:0]      in_dvs,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [N-1:0]      out_quo_a,
    output logic [N-1:0]      out_quo_b,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [N];
    logic [D-1:0]      rem_a_reg[N];
    logic [D-1:0]      rem_b_reg[N];
    logic [N-1:0]      q_a_reg  [N];
    logic [N-1:0]      q_b_reg  [N];
    logic [D-1:0]      dvs_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic              v_prev;
        logic [D-1:0]      rem_a_prev, rem_b_prev, dvs_prev;
        logic [N-1:0]      q_a_prev, q_b_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [D:0]        tmp_a, tmp_b, dif_a, dif_b;
        logic              ge_a, ge_b;

        if (k == 0) begin : g_first
            assign v_prev     = in_valid;
            assign rem_a_prev = '0;
            assign rem_b_prev = '0;
            assign q_a_prev   = in_dvd_a;
            assign q_b_prev   = in_dvd_b;
            assign dvs_prev   = in_dvs;
            assign side_prev  = in_side;
        end else begin : g_rest
            assign v_prev     = v_reg[k-1];
            assign rem_a_prev = rem_a_reg[k-1];
            assign rem_b_prev = rem_b_reg[k-1];
            assign q_a_prev   = q_a_reg[k-1];
            assign q_b_prev   = q_b_reg[k-1];
            assign dvs_prev   = dvs_reg[k-1];
            assign side_prev  = side_reg[k-1];
        end

        always_comb begin
            tmp_a = {rem_a_prev, q_a_prev[N-1]};
            tmp_b = {rem_b_prev, q_b_prev[N-1]};
            dif_a = tmp_a - {1'b0, dvs_prev};
            dif_b = tmp_b - {1'b0, dvs_prev};
            ge_a  = (tmp_a >= {1'b0, dvs_prev});
            ge_b  = (tmp_b >= {1'b0, dvs_prev});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_a_reg[k] <= ge_a ? dif_a[D-1:0] : tmp_a[D-1:0];
                rem_b_reg[k] <= ge_b ? dif_b[D-1:0] : tmp_b[D-1:0];
                q_a_reg[k]   <= {q_a_prev[N-2:0], ge_a};
                q_b_reg[k]   <= {q_b_prev[N-2:0], ge_b};
                dvs_reg[k]   <= dvs_prev;
                side_reg[k]  <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_quo_a = q_a_reg[N-1];
    assign out_quo_b = q_b_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

@@ rtl/circle_collision_impulse.sv @@
// throughput: one item per cycle; the whole pipe freezes only while a result waits
// depth is set by the 16-stage root, the 30-stage normal divider and the 38-stage
// impulse divider, each one bit per stage
// reset: aresetn low clears all valid bits and sets restitution to 230 (0.9)
`default_nettype none
`include "assert_macros.svh"

module circle_collision_impulse (
    input  logic                              aclk,
    input  logic                              aresetn,
    // restitution register, unsigned q1.8
    input  logic                              cfg_wr_en,
    input  logic [cci_pkg::RST_W-1:0]         cfg_wr_data,
    // input item
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x, first_vel_y,
    // second_vel_x, second_vel_y, radius_sum, first_inv_mass, second_inv_mass,
    // both_active, zero pad
    input  logic [cci_pkg::IN_DATA_W-1:0]     s_tdata,
    // result item
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // new_first_pos_x, new_first_pos_y, new_second_pos_x, new_second_pos_y,
    // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
    // contact, mass_error, zero pad
    output logic [cci_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int PW = cci_pkg::POS_W;
    localparam int VW = cci_pkg::VEL_W;
    localparam int DW = cci_pkg::DIST_W;
    localparam int JN = cci_pkg::JD_N;
    localparam int NF = cci_pkg::NORM_FRAC;
    localparam int MF = cci_pkg::MASS_FRAC;
    localparam int IW = cci_pkg::IMS_W;
    localparam int SUM_W = 44;

    typedef struct packed {
        logic [PW-1:0]               apx, apy, bpx, bpy;
        logic [VW-1:0]               avx, avy, bvx, bvy;
        logic [cci_pkg::RSUM_W-1:0]  rsum;
        logic [cci_pkg::IM_W-1:0]    ima, imb;
        logic                        active;
    } item_t;

    typedef struct packed {
        item_t         item;
        logic          dxn, dyn;
        logic [DW-1:0] dxm, dym;
        logic          far, zero;
    } sq_side_t;

    typedef struct packed {
        item_t         item;
        logic          dxn, dyn;
        logic          contact, merr;
        logic [IW-1:0] ims;
        logic [DW-1:0] ovl;
    } nd_side_t;

    typedef struct packed {
        nd_side_t      nd;
        logic [NF:0]   nxm, nym;
    } mid_t;

    typedef struct packed {
        item_t       item;
        logic        dxn, dyn;
        logic        contact;
        logic        merr;
        logic [NF:0] nxm, nym;
    } jd_side_t;

    // ---------------------------------------------------------------- control
    logic ce;
    assign ce       = !m_tvalid || m_tready;   // the whole pipe moves together
    assign s_tready = ce;

    logic [cci_pkg::RST_W-1:0] restitution_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restitution_reg <= cci_pkg::RST_RESET;
        end else if (cfg_wr_en) begin
            restitution_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------- unpack
    item_t in_item;
    assign in_item.apx    = s_tdata[19:0];
    assign in_item.apy    = s_tdata[39:20];
    assign in_item.bpx    = s_tdata[59:40];
    assign in_item.bpy    = s_tdata[79:60];
    assign in_item.avx    = s_tdata[100:80];
    assign in_item.avy    = s_tdata[121:101];
    assign in_item.bvx    = s_tdata[142:122];
    assign in_item.bvy    = s_tdata[163:143];
    assign in_item.rsum   = s_tdata[179:164];
    assign in_item.ima    = s_tdata[195:180];
    assign in_item.imb    = s_tdata[211:196];
    assign in_item.active = s_tdata[212];

    // ---------------------------------------------------------------- s1: d = a - b
    logic          s1_valid_reg;
    item_t         s1_item_reg;
    logic [PW:0]   s1_dxm_reg, s1_dym_reg;
    logic          s1_dxn_reg, s1_dyn_reg;
    logic [PW:0]   dx_next, dy_next;

    assign dx_next = {in_item.apx[PW-1], in_item.apx} - {in_item.bpx[PW-1], in_item.bpx};
    assign dy_next = {in_item.apy[PW-1], in_item.apy} - {in_item.bpy[PW-1], in_item.bpy};

    // ---------------------------------------------------------------- s2: squares
    logic              s2_valid_reg;
    item_t             s2_item_reg;
    logic [PW:0]       s2_dxm_reg, s2_dym_reg;
    logic              s2_dxn_reg, s2_dyn_reg;
    logic [2*PW+1:0]   s2_sqx_reg, s2_sqy_reg;

    // ---------------------------------------------------------------- s3: sum, range
    logic              s3_valid_reg;
    sq_side_t          s3_side_reg;
    logic [cci_pkg::SQ_W-1:0] s3_x_reg;
    logic [2*PW+1:0]   d2_next;

    assign d2_next = s2_sqx_reg + s2_sqy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_item_reg <= in_item;
            s1_dxn_reg  <= dx_next[PW];
            s1_dyn_reg  <= dy_next[PW];
            s1_dxm_reg  <= dx_next[PW] ? (~dx_next + 1'b1) : dx_next;
            s1_dym_reg  <= dy_next[PW] ? (~dy_next + 1'b1) : dy_next;

            s2_item_reg <= s1_item_reg;
            s2_dxn_reg  <= s1_dxn_reg;
            s2_dyn_reg  <= s1_dyn_reg;
            s2_dxm_reg  <= s1_dxm_reg;
            s2_dym_reg  <= s1_dym_reg;
            s2_sqx_reg  <= (2*PW+2)'(s1_dxm_reg) * (2*PW+2)'(s1_dxm_reg);
            s2_sqy_reg  <= (2*PW+2)'(s1_dym_reg) * (2*PW+2)'(s1_dym_reg);

            // beyond 2^32 the distance is at least 2^16 and cannot beat radius_sum
            s3_side_reg.item <= s2_item_reg;
            s3_side_reg.dxn  <= s2_dxn_reg;
            s3_side_reg.dyn  <= s2_dyn_reg;
            s3_side_reg.dxm  <= s2_dxm_reg[DW-1:0];
            s3_side_reg.dym  <= s2_dym_reg[DW-1:0];
            s3_side_reg.far  <= |d2_next[2*PW+1:cci_pkg::SQ_W];
            s3_side_reg.zero <= (d2_next == '0);
            s3_x_reg         <= d2_next[cci_pkg::SQ_W-1:0];
        end
    end

    // ---------------------------------------------------------------- distance
    logic                sq_valid;
    logic [DW-1:0]       sq_root;
    logic [$bits(sq_side_t)-1:0] sq_side_vec;
    sq_side_t            sq_side;

    cci_sqrt #(
        .X_W    (cci_pkg::SQ_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (ce),
        .in_valid  (s3_valid_reg),
        .in_x      (s3_x_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_vec)
    );

    assign sq_side = sq_side_vec;

    // overlap test and inverse mass sum ride into the normal divider
    nd_side_t nd_in;
    logic     hit;

    always_comb begin
        hit           = sq_side.item.active && !sq_side.zero && !sq_side.far
                        && (sq_side.item.rsum > sq_root);
        nd_in.item    = sq_side.item;
        nd_in.dxn     = sq_side.dxn;
        nd_in.dyn     = sq_side.dyn;
        nd_in.ims     = {1'b0, sq_side.item.ima} + {1'b0, sq_side.item.imb};
        nd_in.contact = hit && (nd_in.ims != '0);
        nd_in.merr    = hit && (nd_in.ims == '0);
        nd_in.ovl     = sq_side.item.rsum - sq_root;
    end

    // ---------------------------------------------------------------- unit normal
    logic                        n_valid;
    logic [cci_pkg::ND_N-1:0]    n_qx, n_qy;
    logic [$bits(nd_side_t)-1:0] n_side_vec;
    nd_side_t                    n_side;

    cci_div #(
        .N      (cci_pkg::ND_N),
        .D      (DW),
        .SIDE_W ($bits(nd_side_t))
    ) u_norm_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (ce),
        .in_valid  (sq_valid),
        .in_dvd_a  ({sq_side.dxm, {NF{1'b0}}}),
        .in_dvd_b  ({sq_side.dym, {NF{1'b0}}}),
        .in_dvs    (sq_root),
        .in_side   (nd_in),
        .out_valid (n_valid),
        .out_quo_a (n_qx),
        .out_quo_b (n_qy),
        .out_side  (n_side_vec)
    );

    assign n_side = n_side_vec;

    // ---------------------------------------------------------------- s5..s9: vn and J numerator
    localparam int RST_W_L = cci_pkg::RST_W + 1;

    logic            s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg;
    mid_t            s5_mid_reg, s6_mid_reg, s7_mid_reg, s8_mid_reg, s9_mid_reg;
    logic [NF+1:0]   s5_nx_reg, s5_ny_reg;
    logic [VW:0]     s5_rvx_reg, s5_rvy_reg;
    logic signed [VW+NF+2:0] s6_px_reg, s6_py_reg;
    logic [VW+NF+3:0]        s7_dot_reg;
    logic [VW+2:0]   s8_vnm_reg;
    logic            s8_vneg_reg;
    logic [JN-1:0]   s9_num_reg, s9_cnum_reg;

    mid_t            mid_next;
    logic [NF+1:0]   nx_next, ny_next;
    logic [VW+NF+3:0] dmag_next;
    logic [RST_W_L-1:0] kfac_next;
    logic [JN-5:0]   jprod_next;

    always_comb begin
        mid_next.nd  = n_side;
        mid_next.nxm = n_qx[NF:0];
        mid_next.nym = n_qy[NF:0];
        nx_next      = n_side.dxn ? (~{1'b0, n_qx[NF:0]} + 1'b1) : {1'b0, n_qx[NF:0]};
        ny_next      = n_side.dyn ? (~{1'b0, n_qy[NF:0]} + 1'b1) : {1'b0, n_qy[NF:0]};
        dmag_next    = s7_dot_reg[VW+NF+3] ? (~s7_dot_reg + 1'b1) : s7_dot_reg;
        kfac_next    = {1'b0, restitution_reg} + cci_pkg::ONE_Q8;
        jprod_next   = (JN-4)'(kfac_next) * (JN-4)'(s8_vnm_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end else if (ce) begin
            s5_valid_reg <= n_valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // relative velocity and signed normal
            s5_mid_reg  <= mid_next;
            s5_nx_reg   <= nx_next;
            s5_ny_reg   <= ny_next;
            s5_rvx_reg  <= {n_side.item.avx[VW-1], n_side.item.avx}
                           - {n_side.item.bvx[VW-1], n_side.item.bvx};
            s5_rvy_reg  <= {n_side.item.avy[VW-1], n_side.item.avy}
                           - {n_side.item.bvy[VW-1], n_side.item.bvy};

            s6_mid_reg  <= s5_mid_reg;
            s6_px_reg   <= $signed(s5_rvx_reg) * $signed(s5_nx_reg);
            s6_py_reg   <= $signed(s5_rvy_reg) * $signed(s5_ny_reg);

            s7_mid_reg  <= s6_mid_reg;
            s7_dot_reg  <= {s6_px_reg[VW+NF+2], s6_px_reg} + {s6_py_reg[VW+NF+2], s6_py_reg};

            // vn truncated toward zero; approaching only when it is below zero
            s8_mid_reg  <= s7_mid_reg;
            s8_vnm_reg  <= dmag_next[VW+NF+2:NF];
            s8_vneg_reg <= s7_dot_reg[VW+NF+3] && (dmag_next[VW+NF+3:NF] != '0);

            s9_mid_reg  <= s8_mid_reg;
            s9_num_reg  <= s8_vneg_reg ? {jprod_next, 4'b0000} : '0;
            s9_cnum_reg <= {{(JN-DW-MF){1'b0}}, s8_mid_reg.nd.ovl, {MF{1'b0}}};
        end
    end

    // ---------------------------------------------------------------- J and C
    jd_side_t jd_in;

    always_comb begin
        jd_in.item    = s9_mid_reg.nd.item;
        jd_in.dxn     = s9_mid_reg.nd.dxn;
        jd_in.dyn     = s9_mid_reg.nd.dyn;
        jd_in.contact = s9_mid_reg.nd.contact;
        jd_in.merr    = s9_mid_reg.nd.merr;
        jd_in.nxm     = s9_mid_reg.nxm;
        jd_in.nym     = s9_mid_reg.nym;
    end

    logic                        j_valid;
    logic [JN-1:0]               j_quo, c_quo;
    logic [$bits(jd_side_t)-1:0] j_side_vec;
    jd_side_t                    j_side;

    cci_div #(
        .N      (JN),
        .D      (IW),
        .SIDE_W ($bits(jd_side_t))
    ) u_imp_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (ce),
        .in_valid  (s9_valid_reg),
        .in_dvd_a  (s9_num_reg),
        .in_dvd_b  (s9_cnum_reg),
        .in_dvs    (s9_mid_reg.nd.ims),
        .in_side   (jd_in),
        .out_valid (j_valid),
        .out_quo_a (j_quo),
        .out_quo_b (c_quo),
        .out_side  (j_side_vec)
    );

    assign j_side = j_side_vec;

    // ---------------------------------------------------------------- s10, s11: scaling
    localparam int P1_W = JN + NF + 1;
    localparam int P2_W = JN + cci_pkg::IM_W;
    localparam int DL_W = P2_W - MF;

    logic            s10_valid_reg, s11_valid_reg;
    jd_side_t        s10_side_reg, s11_side_reg;
    logic [JN-1:0]   s10_jx_reg, s10_jy_reg, s10_cx_reg, s10_cy_reg;
    logic [DL_W-1:0] s11_dvax_reg, s11_dvay_reg, s11_dvbx_reg, s11_dvby_reg;
    logic [DL_W-1:0] s11_dpax_reg, s11_dpay_reg, s11_dpbx_reg, s11_dpby_reg;
    logic [P1_W-1:0] pjx_next, pjy_next, pcx_next, pcy_next;
    logic [P2_W-1:0] pvax_next, pvay_next, pvbx_next, pvby_next;
    logic [P2_W-1:0] ppax_next, ppay_next, ppbx_next, ppby_next;

    always_comb begin
        pjx_next  = P1_W'(j_quo) * P1_W'(j_side.nxm);
        pjy_next  = P1_W'(j_quo) * P1_W'(j_side.nym);
        pcx_next  = P1_W'(c_quo) * P1_W'(j_side.nxm);
        pcy_next  = P1_W'(c_quo) * P1_W'(j_side.nym);
        pvax_next = P2_W'(s10_jx_reg) * P2_W'(s10_side_reg.item.ima);
        pvay_next = P2_W'(s10_jy_reg) * P2_W'(s10_side_reg.item.ima);
        pvbx_next = P2_W'(s10_jx_reg) * P2_W'(s10_side_reg.item.imb);
        pvby_next = P2_W'(s10_jy_reg) * P2_W'(s10_side_reg.item.imb);
        ppax_next = P2_W'(s10_cx_reg) * P2_W'(s10_side_reg.item.ima);
        ppay_next = P2_W'(s10_cy_reg) * P2_W'(s10_side_reg.item.ima);
        ppbx_next = P2_W'(s10_cx_reg) * P2_W'(s10_side_reg.item.imb);
        ppby_next = P2_W'(s10_cy_reg) * P2_W'(s10_side_reg.item.imb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
        end else if (ce) begin
            s10_valid_reg <= j_valid;
            s11_valid_reg <= s10_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // the normal is at most one, so these stay within the dividend width
            s10_side_reg <= j_side;
            s10_jx_reg   <= pjx_next[JN+NF-1:NF];
            s10_jy_reg   <= pjy_next[JN+NF-1:NF];
            s10_cx_reg   <= pcx_next[JN+NF-1:NF];
            s10_cy_reg   <= pcy_next[JN+NF-1:NF];

            s11_side_reg <= s10_side_reg;
            s11_dvax_reg <= pvax_next[P2_W-1:MF];
            s11_dvay_reg <= pvay_next[P2_W-1:MF];
            s11_dvbx_reg <= pvbx_next[P2_W-1:MF];
            s11_dvby_reg <= pvby_next[P2_W-1:MF];
            s11_dpax_reg <= ppax_next[P2_W-1:MF];
            s11_dpay_reg <= ppay_next[P2_W-1:MF];
            s11_dpbx_reg <= ppbx_next[P2_W-1:MF];
            s11_dpby_reg <= ppby_next[P2_W-1:MF];
        end
    end

    // ---------------------------------------------------------------- output stage
    // signed magnitude delta, zero unless the pair is in contact
    function automatic logic [SUM_W-1:0] delta(input logic neg, input logic gate,
                                               input logic [DL_W-1:0] m);
        logic [SUM_W-1:0] v;
        v = gate ? SUM_W'(m) : '0;
        return neg ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [PW-1:0] sat_pos(input logic [SUM_W-1:0] v);
        logic in_range;
        in_range = (&v[SUM_W-1:PW-1]) || !(|v[SUM_W-1:PW-1]);
        if (in_range) begin
            return v[PW-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    endfunction

    function automatic logic [VW-1:0] sat_vel(input logic [SUM_W-1:0] v);
        logic in_range;
        in_range = (&v[SUM_W-1:VW-1]) || !(|v[SUM_W-1:VW-1]);
        if (in_range) begin
            return v[VW-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    endfunction

    logic                                 m_valid_reg;
    logic [cci_pkg::OUT_DATA_W-1:0]       m_data_reg;
    logic [cci_pkg::OUT_DATA_W-1:0]       m_data_next;
    item_t                                fi;
    logic                                 ct, sx, sy;

    always_comb begin
        fi = s11_side_reg.item;
        ct = s11_side_reg.contact;
        sx = s11_side_reg.dxn;
        sy = s11_side_reg.dyn;
        m_data_next = {
            2'b00,
            s11_side_reg.merr,
            ct,
            sat_vel(SUM_W'($signed(fi.bvy)) - delta(sy, ct, s11_dvby_reg)),
            sat_vel(SUM_W'($signed(fi.bvx)) - delta(sx, ct, s11_dvbx_reg)),
            sat_vel(SUM_W'($signed(fi.avy)) + delta(sy, ct, s11_dvay_reg)),
            sat_vel(SUM_W'($signed(fi.avx)) + delta(sx, ct, s11_dvax_reg)),
            sat_pos(SUM_W'($signed(fi.bpy)) - delta(sy, ct, s11_dpby_reg)),
            sat_pos(SUM_W'($signed(fi.bpx)) - delta(sx, ct, s11_dpbx_reg)),
            sat_pos(SUM_W'($signed(fi.apy)) + delta(sy, ct, s11_dpay_reg)),
            sat_pos(SUM_W'($signed(fi.apx)) + delta(sx, ct, s11_dpax_reg))
        };
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= s11_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------- checks
    // a pair is either resolved or flagged for zero mass, never both
    `ASSERT_IMP(a_flags_exclusive, aclk, aresetn, m_tvalid, !(m_tdata[164] && m_tdata[165]))
    // an accepted item always enters the first stage
    `ASSERT_NXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, s1_valid_reg)
    // a waiting result is held by the frozen pipe
    `ASSERT_NXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready,
                m_tvalid && $stable(m_tdata))

endmodule

`default_nettype wire

@@ bench/circle_collision_impulse_tb.sv @@
// self-checking testbench for the circle collision impulse block
`default_nettype none

module circle_collision_impulse_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W      = cci_pkg::POS_W;
    localparam int VEL_W      = cci_pkg::VEL_W;
    localparam int IM_W       = cci_pkg::IM_W;
    localparam int RSUM_W     = cci_pkg::RSUM_W;
    localparam int RST_W      = cci_pkg::RST_W;
    localparam int IN_DATA_W  = cci_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = cci_pkg::OUT_DATA_W;
    localparam int NORM_FRAC  = cci_pkg::NORM_FRAC;
    localparam int MASS_FRAC  = cci_pkg::MASS_FRAC;
    localparam logic [RST_W-1:0] RST_RESET = cci_pkg::RST_RESET;

    localparam int LATENCY = 95;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]         pad;
        logic               both_active;
        logic [IM_W-1:0]    second_inv_mass;
        logic [IM_W-1:0]    first_inv_mass;
        logic [RSUM_W-1:0]  radius_sum;
        logic signed [VEL_W-1:0] second_vel_y;
        logic signed [VEL_W-1:0] second_vel_x;
        logic signed [VEL_W-1:0] first_vel_y;
        logic signed [VEL_W-1:0] first_vel_x;
        logic signed [POS_W-1:0] second_pos_y;
        logic signed [POS_W-1:0] second_pos_x;
        logic signed [POS_W-1:0] first_pos_y;
        logic signed [POS_W-1:0] first_pos_x;
    } pair_t;

    typedef struct packed {
        logic [1:0]         pad;
        logic               mass_error;
        logic               contact;
        logic signed [VEL_W-1:0] new_second_vel_y;
        logic signed [VEL_W-1:0] new_second_vel_x;
        logic signed [VEL_W-1:0] new_first_vel_y;
        logic signed [VEL_W-1:0] new_first_vel_x;
        logic signed [POS_W-1:0] new_second_pos_y;
        logic signed [POS_W-1:0] new_second_pos_x;
        logic signed [POS_W-1:0] new_first_pos_y;
        logic signed [POS_W-1:0] new_first_pos_x;
    } resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [RST_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    circle_collision_impulse dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // pending pairs for the driver, and the predicted responses in flight
    pair_t pair_q[$];
    resp_t resp_q[$];
    logic [RST_W-1:0] e_reg = RST_RESET;
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;   // long receiver stall requested by the stimulus

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // product over 2^s, truncated toward zero
    function automatic longint scale_trunc(longint a, longint b, int s);
        longint p;
        p = (abs64(a) * abs64(b)) >>> s;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r, b;
        r = 0;
        b = longint'(1) <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // collision response of one pair under the current restitution
    function automatic resp_t resolve_pair(pair_t p, logic [RST_W-1:0] e);
        resp_t r;
        longint apx, apy, bpx, bpy, avx, avy, bvx, bvy;
        longint ima, imb, ims, dx, dy, d2, root_d, nx, ny, dot, vn, j, ix, iy, c, cx, cy;
        apx = longint'(p.first_pos_x);  apy = longint'(p.first_pos_y);
        bpx = longint'(p.second_pos_x); bpy = longint'(p.second_pos_y);
        avx = longint'(p.first_vel_x);  avy = longint'(p.first_vel_y);
        bvx = longint'(p.second_vel_x); bvy = longint'(p.second_vel_y);
        ima = longint'(p.first_inv_mass); imb = longint'(p.second_inv_mass);
        r = '0;
        if (p.both_active) begin
            dx = apx - bpx;
            dy = apy - bpy;
            d2 = dx * dx + dy * dy;
            root_d = int_sqrt(d2);
            if (d2 != 0 && longint'(p.radius_sum) > root_d) begin
                ims = ima + imb;
                if (ims == 0) begin
                    r.mass_error = 1'b1;
                end else begin
                    nx = (abs64(dx) <<< NORM_FRAC) / root_d;
                    ny = (abs64(dy) <<< NORM_FRAC) / root_d;
                    if (dx < 0) nx = -nx;
                    if (dy < 0) ny = -ny;
                    dot = (avx - bvx) * nx + (avy - bvy) * ny;
                    vn = abs64(dot) >>> NORM_FRAC;
                    if (dot < 0) vn = -vn;
                    if (vn < 0) begin
                        j = (((longint'(e) + 256) * -vn) <<< 4) / ims;
                        ix = scale_trunc(j, nx, NORM_FRAC);
                        iy = scale_trunc(j, ny, NORM_FRAC);
                        avx += scale_trunc(ix, ima, MASS_FRAC);
                        avy += scale_trunc(iy, ima, MASS_FRAC);
                        bvx -= scale_trunc(ix, imb, MASS_FRAC);
                        bvy -= scale_trunc(iy, imb, MASS_FRAC);
                    end
                    c = ((longint'(p.radius_sum) - root_d) <<< MASS_FRAC) / ims;
                    cx = scale_trunc(c, nx, NORM_FRAC);
                    cy = scale_trunc(c, ny, NORM_FRAC);
                    apx += scale_trunc(cx, ima, MASS_FRAC);
                    apy += scale_trunc(cy, ima, MASS_FRAC);
                    bpx -= scale_trunc(cx, imb, MASS_FRAC);
                    bpy -= scale_trunc(cy, imb, MASS_FRAC);
                    r.contact = 1'b1;
                end
            end
        end
        r.new_first_pos_x  = POS_W'(clamp(apx, POS_W));
        r.new_first_pos_y  = POS_W'(clamp(apy, POS_W));
        r.new_second_pos_x = POS_W'(clamp(bpx, POS_W));
        r.new_second_pos_y = POS_W'(clamp(bpy, POS_W));
        r.new_first_vel_x  = VEL_W'(clamp(avx, VEL_W));
        r.new_first_vel_y  = VEL_W'(clamp(avy, VEL_W));
        r.new_second_vel_x = VEL_W'(clamp(bvx, VEL_W));
        r.new_second_vel_y = VEL_W'(clamp(bvy, VEL_W));
        return r;
    endfunction

    // mostly short gaps, now and then a long one, sometimes none for a while
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: offers pairs from the pending queue, predicts at acceptance
    int s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                resp_q.push_back(resolve_pair(pair_t'(s_tdata), e_reg));
                s_gap = gap_len();
            end
            if (s_tvalid && !s_tready) begin
                // keep offering the same item
            end else if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (pair_q.size() > 0) begin
                s_tdata <= pair_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compares each accepted response with the oldest prediction
    int m_gap = 0;
    int stall_left = 0;
    always @(posedge aclk) begin
        resp_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = resp_t'(m_tdata);
                if (resp_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected response: got %h", $time, got);
                end else begin
                    want = resp_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t mismatch: expected %h, got %h", $time, want, got);
                    end
                end
                m_gap = gap_len();
            end
            if (hold_off && stall_left == 0) begin
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [POS_W-1:0] rnd_pos();
        return POS_W'($urandom);
    endfunction

    function automatic logic signed [VEL_W-1:0] rnd_vel();
        return VEL_W'($urandom);
    endfunction

    // nearby pair with random content; near range keeps contacts frequent
    function automatic pair_t near_pair();
        pair_t p;
        int span;
        p = '0;
        span = ($urandom_range(0, 9) == 0) ? 65535 : 4000;
        p.first_pos_x = ($urandom_range(0, 19) == 0) ? rnd_pos()
                        : POS_W'(int'($urandom_range(0, 200000)) - 100000);
        p.first_pos_y = POS_W'(int'($urandom_range(0, 200000)) - 100000);
        p.second_pos_x = p.first_pos_x + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
        p.second_pos_y = p.first_pos_y + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
        p.first_vel_x = rnd_vel();
        p.first_vel_y = rnd_vel();
        p.second_vel_x = rnd_vel();
        p.second_vel_y = rnd_vel();
        if ($urandom_range(0, 3) == 0) begin
            p.first_vel_x = p.first_vel_x >>> 8;
            p.second_vel_y = p.second_vel_y >>> 8;
        end
        p.radius_sum = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
        p.first_inv_mass = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
        p.second_inv_mass = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
        p.both_active = ($urandom_range(0, 19) != 0);
        return p;
    endfunction

    function automatic pair_t noise_pair();
        pair_t p;
        p = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom});
        p.pad = '0;
        return p;
    endfunction

    task automatic wait_drained();
        while (pair_q.size() > 0 || s_tvalid || resp_q.size() > 0) @(negedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic set_restitution(logic [RST_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        e_reg = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        pair_t p;
        logic [RST_W-1:0] settings [4] = '{9'd0, 9'd256, 9'd511, 9'd128};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed pairs under the reset restitution
        p = '0;
        pair_q.push_back(p);                              // inactive, all zero
        p.both_active = 1'b1;
        pair_q.push_back(p);                              // coincident centers
        p.radius_sum = 16'hFFFF;
        p.first_pos_x = 20'sh7FFFF; p.second_pos_x = 20'sh80000;  // far apart
        pair_q.push_back(p);
        p.first_pos_x = 20'sd256; p.second_pos_x = '0;    // overlap, zero masses
        pair_q.push_back(p);
        p.first_inv_mass = 16'h1000; p.second_inv_mass = 16'h1000;
        p.first_vel_x = -21'sd2560; p.second_vel_x = 21'sd2560;   // approaching
        pair_q.push_back(p);
        p.first_vel_x = 21'sd2560; p.second_vel_x = -21'sd2560;   // separating
        pair_q.push_back(p);
        p.first_vel_x = '0; p.second_vel_x = '0;          // resting
        pair_q.push_back(p);
        p.first_inv_mass = 16'hFFFF; p.second_inv_mass = 16'h0000;
        p.first_vel_x = 21'sh100000; p.second_vel_x = 21'shFFFFF; // extreme speeds
        p.first_vel_y = 21'shFFFFF; p.second_vel_y = 21'sh100000;
        pair_q.push_back(p);
        p.first_pos_x = 20'sh7FFFF; p.second_pos_x = 20'sh7FF00;  // pushes into saturation
        p.first_pos_y = 20'sh80000; p.second_pos_y = 20'sh80080;
        p.first_inv_mass = 16'h0000; p.second_inv_mass = 16'hFFFF;
        pair_q.push_back(p);
        p.both_active = 1'b0;                             // same pair, inactive
        pair_q.push_back(p);
        for (int i = 0; i < 10; i++) pair_q.push_back(near_pair());
        wait_drained();

        // random phases over several restitution settings, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            set_restitution(settings[ph]);
            for (int i = 0; i < 440; i++) begin
                pair_q.push_back(($urandom_range(0, 9) < 8) ? near_pair() : noise_pair());
                if (ph == 1 && i == 100) begin
                    // receiver holds off while the sender keeps offering
                    while (pair_q.size() > 0) @(negedge aclk);
                    hold_off = 1'b1;
                    @(negedge aclk);
                    hold_off = 1'b0;
                end
                if (ph == 2 && i == 200) begin
                    // sender pauses until every response is in
                    while (pair_q.size() > 0 || s_tvalid || resp_q.size() > 0) @(negedge aclk);
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/cci_pkg.sv
rtl/cci_sqrt.sv
rtl/cci_div.sv
rtl/circle_collision_impulse.sv
bench/circle_collision_impulse_tb.sv
